@@ rtl/ism_pkg.sv @@
// Shared types and codes for the interval set merge engine.
package ism_pkg;

    localparam int CPW = 21;

    // Action codes of the input channel
    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_APP_A  = 3'd1;
    localparam logic [2:0] ACT_APP_B  = 3'd2;
    localparam logic [2:0] ACT_UNION  = 3'd3;
    localparam logic [2:0] ACT_INTER  = 3'd4;
    localparam logic [2:0] ACT_DIFF   = 3'd5;
    localparam logic [2:0] ACT_QUERY  = 3'd6;
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    // Append status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One result item without its last mark
    typedef struct packed {
        logic [CPW-1:0] lo;
        logic [CPW-1:0] hi;
        logic           member;
        logic [1:0]     status;
        logic           empty;
    } t_res;

    // Requests from the sequencer to the result queue
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_FINISH,
        OP_SINGLE
    } t_op;

    typedef struct packed {
        t_op  op;
        t_res res;
    } t_oreq;

    localparam t_res RES_ZERO  = '{lo: '0, hi: '0, member: 1'b0, status: ST_OK, empty: 1'b0};
    localparam t_res RES_EMPTY = '{lo: '0, hi: '0, member: 1'b0, status: ST_OK, empty: 1'b1};

endpackage

@@ rtl/ism_ram.sv @@
// Interval store: one write port, one read port with registered read data.
module ism_ram import ism_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 42,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write the appended interval
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read word
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ism_outq.sv @@
// Result queue: holds one pending interval until the next one shows whether it is last.
module ism_outq import ism_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_oreq i_req,
    output logic  o_ack,
    input  logic  i_stall,
    output logic  o_valid,
    output t_res  o_res,
    output logic  o_last
);

    logic r_valid;
    logic r_last;
    logic r_pend_v;
    t_res r_res;
    t_res r_pend;
    logic out_free;
    logic load_out;

    assign out_free = !r_valid || !i_stall;

    // Grant the request when its target register can take it
    always_comb begin
        unique case (i_req.op)
            OP_PUSH:   o_ack = !r_pend_v || out_free;
            OP_FINISH: o_ack = out_free;
            OP_SINGLE: o_ack = out_free;
            default:   o_ack = 1'b0;
        endcase
    end

    // A granted request fills the output register unless it only fills the pending slot
    assign load_out = o_ack && ((i_req.op != OP_PUSH) || r_pend_v);

    // Advance pending and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_pend_v <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            // Load the output register, or drop it once its transfer is done
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            if (o_ack) begin
                unique case (i_req.op)
                    OP_PUSH: begin
                        if (r_pend_v) begin
                            r_res  <= r_pend;
                            r_last <= 1'b0;
                        end
                        r_pend   <= i_req.res;
                        r_pend_v <= 1'b1;
                    end
                    OP_FINISH: begin
                        r_last   <= 1'b1;
                        r_res    <= r_pend_v ? r_pend : RES_EMPTY;
                        r_pend_v <= 1'b0;
                    end
                    OP_SINGLE: begin
                        r_last <= 1'b1;
                        r_res  <= i_req.res;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

endmodule

@@ rtl/ism_seq.sv @@
// Sequencer: decodes items and walks both interval lists one step at a time.
module ism_seq import ism_pkg::*; #(
    parameter int MAX_RANGES = 16,
    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
    localparam int CW = $clog2(MAX_RANGES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [2:0]       i_action,
    input  logic [CPW-1:0]   i_range_low,
    input  logic [CPW-1:0]   i_range_high,
    output logic             o_busy,
    output logic             o_a_we,
    output logic [AW-1:0]    o_a_waddr,
    output logic [AW-1:0]    o_a_raddr,
    input  logic [2*CPW-1:0] i_a_rdata,
    output logic             o_b_we,
    output logic [AW-1:0]    o_b_waddr,
    output logic [AW-1:0]    o_b_raddr,
    input  logic [2*CPW-1:0] i_b_rdata,
    output logic [2*CPW-1:0] o_wdata,
    output t_oreq            o_req,
    input  logic             i_ack
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_APP,
        S_UNION,
        S_INTER,
        S_DLOAD,
        S_DSKIP,
        S_DINNER,
        S_QUERY
    } t_state;

    t_state         r_state, n_state;
    logic           r_eval, n_eval;
    logic           r_to_b, n_to_b;
    logic           r_run, n_run;
    logic [CW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_j, n_j;
    logic [CW-1:0]  r_k, n_k;
    logic [CW-1:0]  r_cnt_a, n_cnt_a;
    logic [CW-1:0]  r_cnt_b, n_cnt_b;
    logic [CPW-1:0] r_last_a, n_last_a;
    logic [CPW-1:0] r_last_b, n_last_b;
    logic [CPW-1:0] r_lo, n_lo;
    logic [CPW-1:0] r_hi, n_hi;

    logic [CPW-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [CW-1:0]  b_idx;
    logic           a_ok, bj_ok, bk_ok;
    logic [CPW:0]   hi_next;
    logic [CW-1:0]  app_cnt;
    logic [CPW-1:0] app_last;
    logic           app_bad, app_full;
    logic           take_a, more_a, more_b, gap, tail, isect;
    logic [CPW-1:0] mx_lo, mn_hi;

    // Unpack read words and form list bounds
    assign a_lo    = i_a_rdata[CPW-1:0];
    assign a_hi    = i_a_rdata[2*CPW-1:CPW];
    assign b_lo    = i_b_rdata[CPW-1:0];
    assign b_hi    = i_b_rdata[2*CPW-1:CPW];
    assign b_idx   = (r_state == S_DINNER) ? r_k : r_j;
    assign a_ok    = r_i < r_cnt_a;
    assign bj_ok   = r_j < r_cnt_b;
    assign bk_ok   = r_k < r_cnt_b;
    assign hi_next = {1'b0, r_hi} + {{CPW{1'b0}}, 1'b1};

    // Append checks against the last stored end
    assign app_cnt  = r_to_b ? r_cnt_b : r_cnt_a;
    assign app_last = r_to_b ? r_last_b : r_last_a;
    assign app_bad  = (r_hi < r_lo) ||
                      ((app_cnt != '0) &&
                       ({1'b0, r_lo} <= ({1'b0, app_last} + {{CPW{1'b0}}, 1'b1})));
    assign app_full = app_cnt == CW'(MAX_RANGES);

    // Shared compare terms of the walk steps
    assign take_a = !bj_ok || (a_ok && (a_lo <= b_lo));
    assign more_a = a_ok && ({1'b0, a_lo} <= hi_next);
    assign more_b = bj_ok && ({1'b0, b_lo} <= hi_next);
    assign mx_lo  = (a_lo > b_lo) ? a_lo : b_lo;
    assign mn_hi  = (a_hi < b_hi) ? a_hi : b_hi;
    assign isect  = mx_lo <= mn_hi;
    assign gap    = b_lo > r_lo;
    assign tail   = r_lo <= r_hi;

    assign o_busy    = r_state != S_IDLE;
    assign o_a_raddr = r_i[AW-1:0];
    assign o_b_raddr = b_idx[AW-1:0];
    assign o_a_waddr = r_cnt_a[AW-1:0];
    assign o_b_waddr = r_cnt_b[AW-1:0];
    assign o_wdata   = {r_hi, r_lo};

    // Next state of the sequencer
    always_comb begin
        n_state  = r_state;
        n_eval   = r_eval;
        n_to_b   = r_to_b;
        n_run    = r_run;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_last_a = r_last_a;
        n_last_b = r_last_b;
        n_lo     = r_lo;
        n_hi     = r_hi;
        o_req    = '{op: OP_NONE, res: RES_ZERO};
        o_a_we   = 1'b0;
        o_b_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_lo   = i_range_low;
                    n_hi   = i_range_high;
                    n_i    = '0;
                    n_j    = '0;
                    n_k    = '0;
                    n_run  = 1'b0;
                    n_eval = 1'b0;
                    n_to_b = i_action == ACT_APP_B;
                    unique case (i_action)
                        ACT_CLEAR: n_state = S_CLEAR;
                        ACT_APP_A: n_state = S_APP;
                        ACT_APP_B: n_state = S_APP;
                        ACT_UNION: n_state = S_UNION;
                        ACT_INTER: n_state = S_INTER;
                        ACT_DIFF:  n_state = S_DLOAD;
                        ACT_QUERY: n_state = S_QUERY;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end

            S_CLEAR: begin
                o_req.op = OP_SINGLE;
                if (i_ack) begin
                    n_cnt_a = '0;
                    n_cnt_b = '0;
                    n_state = S_IDLE;
                end
            end

            S_APP: begin
                o_req.op = OP_SINGLE;
                priority if (app_bad) begin
                    o_req.res.status = ST_ORDER;
                end else if (app_full) begin
                    o_req.res.status = ST_FULL;
                end else begin
                    o_req.res.status = ST_OK;
                end
                if (i_ack) begin
                    n_state = S_IDLE;
                    if (!app_bad && !app_full) begin
                        if (r_to_b) begin
                            o_b_we   = 1'b1;
                            n_cnt_b  = r_cnt_b + 1'b1;
                            n_last_b = r_hi;
                        end else begin
                            o_a_we   = 1'b1;
                            n_cnt_a  = r_cnt_a + 1'b1;
                            n_last_a = r_hi;
                        end
                    end
                end
            end

            S_UNION: begin
                if (!r_eval) begin
                    n_eval = 1'b1;
                end else if (!r_run) begin
                    if (!a_ok && !bj_ok) begin
                        o_req.op = OP_FINISH;
                        if (i_ack) n_state = S_IDLE;
                    end else begin
                        if (take_a) begin
                            n_lo = a_lo;
                            n_hi = a_hi;
                            n_i  = r_i + 1'b1;
                        end else begin
                            n_lo = b_lo;
                            n_hi = b_hi;
                            n_j  = r_j + 1'b1;
                        end
                        n_run  = 1'b1;
                        n_eval = 1'b0;
                    end
                end else begin
                    // Absorb touching intervals, A first
                    priority if (more_a) begin
                        if (a_hi > r_hi) n_hi = a_hi;
                        n_i    = r_i + 1'b1;
                        n_eval = 1'b0;
                    end else if (more_b) begin
                        if (b_hi > r_hi) n_hi = b_hi;
                        n_j    = r_j + 1'b1;
                        n_eval = 1'b0;
                    end else begin
                        o_req.op     = OP_PUSH;
                        o_req.res.lo = r_lo;
                        o_req.res.hi = r_hi;
                        if (i_ack) begin
                            n_run  = 1'b0;
                            n_eval = 1'b0;
                        end
                    end
                end
            end

            S_INTER: begin
                if (!r_eval) begin
                    n_eval = 1'b1;
                end else if (!a_ok || !bj_ok) begin
                    o_req.op = OP_FINISH;
                    if (i_ack) n_state = S_IDLE;
                end else begin
                    if (isect) begin
                        o_req.op     = OP_PUSH;
                        o_req.res.lo = mx_lo;
                        o_req.res.hi = mn_hi;
                    end
                    if (!isect || i_ack) begin
                        if (a_hi < b_hi) n_i = r_i + 1'b1;
                        else             n_j = r_j + 1'b1;
                        n_eval = 1'b0;
                    end
                end
            end

            S_DLOAD: begin
                if (!r_eval) begin
                    n_eval = 1'b1;
                end else if (!a_ok) begin
                    o_req.op = OP_FINISH;
                    if (i_ack) n_state = S_IDLE;
                end else begin
                    n_lo    = a_lo;
                    n_hi    = a_hi;
                    n_state = S_DSKIP;
                    n_eval  = 1'b0;
                end
            end

            S_DSKIP: begin
                if (!r_eval) begin
                    n_eval = 1'b1;
                end else if (bj_ok && (b_hi < r_lo)) begin
                    n_j    = r_j + 1'b1;
                    n_eval = 1'b0;
                end else begin
                    n_k     = r_j;
                    n_state = S_DINNER;
                    n_eval  = 1'b0;
                end
            end

            S_DINNER: begin
                if (!r_eval) begin
                    n_eval = 1'b1;
                end else if (bk_ok && (b_lo <= r_hi)) begin
                    // Emit the gap before this B interval, then cut past it
                    if (gap) begin
                        o_req.op     = OP_PUSH;
                        o_req.res.lo = r_lo;
                        o_req.res.hi = b_lo - 1'b1;
                    end
                    if (!gap || i_ack) begin
                        if (b_hi >= r_hi) begin
                            n_i     = r_i + 1'b1;
                            n_state = S_DLOAD;
                        end else begin
                            n_lo = b_hi + 1'b1;
                            n_k  = r_k + 1'b1;
                        end
                        n_eval = 1'b0;
                    end
                end else begin
                    if (tail) begin
                        o_req.op     = OP_PUSH;
                        o_req.res.lo = r_lo;
                        o_req.res.hi = r_hi;
                    end
                    if (!tail || i_ack) begin
                        n_i     = r_i + 1'b1;
                        n_state = S_DLOAD;
                        n_eval  = 1'b0;
                    end
                end
            end

            S_QUERY: begin
                if (!r_eval) begin
                    n_eval = 1'b1;
                end else if (!a_ok) begin
                    o_req.op = OP_SINGLE;
                    if (i_ack) n_state = S_IDLE;
                end else if ((r_lo >= a_lo) && (r_lo <= a_hi)) begin
                    o_req.op         = OP_SINGLE;
                    o_req.res.member = 1'b1;
                    if (i_ack) n_state = S_IDLE;
                end else begin
                    n_i    = r_i + 1'b1;
                    n_eval = 1'b0;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eval  <= 1'b0;
            r_run   <= 1'b0;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else begin
            r_state <= n_state;
            r_eval  <= n_eval;
            r_run   <= n_run;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
        end
        r_to_b   <= n_to_b;
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_last_a <= n_last_a;
        r_last_b <= n_last_b;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
    end

endmodule

@@ rtl/interval_set_merge_engine_core.sv @@
// Interval set engine top level: two interval stores, walk sequencer and result queue.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+-----------------------------------------------
//  input   | i_valid  | o_stall  | i_action, i_range_low, i_range_high
//  result  | o_valid  | i_stall  | o_out_low, o_out_high, o_is_member, o_status,
//          |          |          | o_empty_result, o_last
//
//  Clear and append send their single result once the queue takes it. Query, union,
//  intersection and difference walk the stores one step at a time (address, then
//  registered read); a step reads an entry, absorbs one into a union run or emits a
//  union interval, and a last address and read end the item when a walk runs off its list.
//  o_stall stays high from the transfer until the last result is in the output register.
//  Reset clears the counts, not the store entries; entries are read only below their count.
//  A result stall holds a single result until the output register frees, and holds the
//  walk at an emit once the pending and output registers are both full.
module interval_set_merge_engine_core import ism_pkg::*; #(
    parameter int MAX_RANGES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [2:0]     i_action,
    input  logic [CPW-1:0] i_range_low,
    input  logic [CPW-1:0] i_range_high,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [CPW-1:0] o_out_low,
    output logic [CPW-1:0] o_out_high,
    output logic           o_is_member,
    output logic [1:0]     o_status,
    output logic           o_empty_result,
    output logic           o_last
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    logic             a_we, b_we;
    logic [AW-1:0]    a_waddr, b_waddr, a_raddr, b_raddr;
    logic [2*CPW-1:0] a_rdata, b_rdata, wdata;
    t_oreq            req;
    logic             ack;
    t_res             res;

    // Walk sequencer
    ism_seq #(.MAX_RANGES(MAX_RANGES)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_action     (i_action),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_busy       (o_stall),
        .o_a_we       (a_we),
        .o_a_waddr    (a_waddr),
        .o_a_raddr    (a_raddr),
        .i_a_rdata    (a_rdata),
        .o_b_we       (b_we),
        .o_b_waddr    (b_waddr),
        .o_b_raddr    (b_raddr),
        .i_b_rdata    (b_rdata),
        .o_wdata      (wdata),
        .o_req        (req),
        .i_ack        (ack)
    );

    // Interval stores for set A and set B
    ism_ram #(.DEPTH(MAX_RANGES), .WIDTH(2*CPW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    ism_ram #(.DEPTH(MAX_RANGES), .WIDTH(2*CPW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // Result queue with last marking
    ism_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_ack   (ack),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (res),
        .o_last  (o_last)
    );

    assign o_out_low      = res.lo;
    assign o_out_high     = res.hi;
    assign o_is_member    = res.member;
    assign o_status       = res.status;
    assign o_empty_result = res.empty;

`ifndef ASSERT_OFF
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_action != ACT_UNUSED) |=> o_stall)
        else $error("sequencer not busy after an input transfer");

    a_busy_needs_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("sequencer became busy without an input transfer");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_result) |-> (o_last && o_out_low == '0 && o_out_high == '0))
        else $error("empty result not a lone last item");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_last && !o_empty_result))
        else $error("append status on a non-final item");
`endif

endmodule

@@ tb/sv/interval_set_merge_engine_core_test.sv @@
// Self-checking testbench for the interval set merge engine core.
module interval_set_merge_engine_core_test;
    import ism_pkg::*;

    localparam int          SET_DEPTH    = 16;
    localparam int          ITEM_TARGET  = 190;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          REPORT_MAX   = 10;
    localparam int unsigned CP_MAX       = (1 << CPW) - 1;

    // One result item as it leaves the block
    typedef struct packed {
        logic [CPW-1:0] lo;
        logic [CPW-1:0] hi;
        logic           member;
        logic [1:0]     status;
        logic           empty;
        logic           last;
    } t_span_result;

    // One input item waiting to be sent
    typedef struct {
        logic [2:0]     act;
        logic [CPW-1:0] lo;
        logic [CPW-1:0] hi;
        int             phase;
        bit             drain;
    } t_set_action;

    logic           i_clk          = 1'b0;
    logic           i_rst_n        = 1'b0;
    logic           i_valid        = 1'b0;
    logic [2:0]     i_action       = ACT_CLEAR;
    logic [CPW-1:0] i_range_low    = '0;
    logic [CPW-1:0] i_range_high   = '0;
    logic           i_stall        = 1'b0;
    logic           o_stall;
    logic           o_valid;
    logic [CPW-1:0] o_out_low;
    logic [CPW-1:0] o_out_high;
    logic           o_is_member;
    logic [1:0]     o_status;
    logic           o_empty_result;
    logic           o_last;

    // Shadow copy of both interval stores: index 0 is set A, index 1 is set B
    int unsigned    set_lo  [2][SET_DEPTH];
    int unsigned    set_hi  [2][SET_DEPTH];
    int unsigned    set_cnt [2];

    t_span_result   spans_due    [$];
    t_set_action    actions_todo [$];

    int             fill_phase  = 0;
    int             rand_count  = 0;
    bit             in_random   = 1'b0;
    int             cur_phase   = 0;
    bit             in_acc      = 1'b0;
    int             mismatches  = 0;
    int             idle_cycles = 0;
    int             hold_left   = 0;
    bit             hold_done   = 1'b0;

    interval_set_merge_engine_core #(
        .MAX_RANGES(SET_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_low     (o_out_low),
        .o_out_high    (o_out_high),
        .o_is_member   (o_is_member),
        .o_status      (o_status),
        .o_empty_result(o_empty_result),
        .o_last        (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Queue one expected result, last mark cleared
    function automatic void emit_span(int unsigned lo, int unsigned hi, bit member,
                                      logic [1:0] st, bit empty);
        t_span_result r;
        r.lo      = lo[CPW-1:0];
        r.hi      = hi[CPW-1:0];
        r.member  = member;
        r.status  = st;
        r.empty   = empty;
        r.last    = 1'b0;
        spans_due = {spans_due, r};
    endfunction

    // Update the shadow sets and queue every result one input item causes
    function automatic void predict_action(logic [2:0] act, logic [CPW-1:0] lo_in,
                                           logic [CPW-1:0] hi_in);
        int unsigned  lo, hi, ca, cb, i, j, k, cur, mark;
        int           s;
        bit           take_a, merging, covered, found;
        logic [1:0]   st;
        lo   = lo_in;
        hi   = hi_in;
        ca   = set_cnt[0];
        cb   = set_cnt[1];
        i    = 0;
        j    = 0;
        mark = spans_due.size();
        case (act)
            ACT_CLEAR: begin
                set_cnt[0] = 0;
                set_cnt[1] = 0;
                emit_span(0, 0, 1'b0, ST_OK, 1'b0);
            end
            ACT_APP_A, ACT_APP_B: begin
                s = (act == ACT_APP_A) ? 0 : 1;
                // order check wins over the capacity check
                if (hi < lo || (set_cnt[s] > 0 && lo <= set_hi[s][set_cnt[s] - 1] + 1)) begin
                    st = ST_ORDER;
                end else if (set_cnt[s] >= SET_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    set_lo[s][set_cnt[s]] = lo;
                    set_hi[s][set_cnt[s]] = hi;
                    set_cnt[s]++;
                    st = ST_OK;
                end
                emit_span(0, 0, 1'b0, st, 1'b0);
            end
            ACT_UNION: begin
                while (i < ca || j < cb) begin
                    take_a = (j >= cb) || (i < ca && set_lo[0][i] <= set_lo[1][j]);
                    if (take_a) begin
                        lo = set_lo[0][i];
                        hi = set_hi[0][i];
                        i++;
                    end else begin
                        lo = set_lo[1][j];
                        hi = set_hi[1][j];
                        j++;
                    end
                    // absorb every interval that overlaps or touches the current one
                    merging = 1'b1;
                    while (merging) begin
                        if (i < ca && set_lo[0][i] <= hi + 1) begin
                            if (set_hi[0][i] > hi) hi = set_hi[0][i];
                            i++;
                        end else if (j < cb && set_lo[1][j] <= hi + 1) begin
                            if (set_hi[1][j] > hi) hi = set_hi[1][j];
                            j++;
                        end else begin
                            merging = 1'b0;
                        end
                    end
                    emit_span(lo, hi, 1'b0, ST_OK, 1'b0);
                end
            end
            ACT_INTER: begin
                while (i < ca && j < cb) begin
                    lo = (set_lo[0][i] > set_lo[1][j]) ? set_lo[0][i] : set_lo[1][j];
                    hi = (set_hi[0][i] < set_hi[1][j]) ? set_hi[0][i] : set_hi[1][j];
                    if (lo <= hi) emit_span(lo, hi, 1'b0, ST_OK, 1'b0);
                    if (set_hi[0][i] < set_hi[1][j]) i++;
                    else j++;
                end
            end
            ACT_DIFF: begin
                for (i = 0; i < ca; i++) begin
                    cur     = set_lo[0][i];
                    hi      = set_hi[0][i];
                    covered = 1'b0;
                    while (j < cb && set_hi[1][j] < cur) j++;
                    // carve out each B interval that reaches into this A interval
                    for (k = j; k < cb && set_lo[1][k] <= hi; k++) begin
                        if (set_lo[1][k] > cur) emit_span(cur, set_lo[1][k] - 1, 1'b0, ST_OK, 1'b0);
                        if (set_hi[1][k] >= hi) begin
                            covered = 1'b1;
                            break;
                        end
                        cur = set_hi[1][k] + 1;
                    end
                    if (!covered && cur <= hi) emit_span(cur, hi, 1'b0, ST_OK, 1'b0);
                end
            end
            ACT_QUERY: begin
                found = 1'b0;
                for (i = 0; i < ca; i++) begin
                    if (lo >= set_lo[0][i] && lo <= set_hi[0][i]) found = 1'b1;
                end
                emit_span(0, 0, found, ST_OK, 1'b0);
            end
            default: return;
        endcase
        if (spans_due.size() == mark) emit_span(0, 0, 1'b0, ST_OK, 1'b1);
        spans_due[spans_due.size() - 1].last = 1'b1;
    endfunction

    function automatic int unsigned idle_pct(bit sender, int phase);
        case (phase)
            0:       return sender ? 13 : 81;
            1:       return sender ? 81 : 13;
            default: return 0;
        endcase
    endfunction

    function automatic logic [2:0] append_code(int s);
        return (s == 0) ? ACT_APP_A : ACT_APP_B;
    endfunction

    // Queue one input item; the first item of a new idle phase waits for a full drain
    function automatic void push_action(logic [2:0] act, int unsigned lo, int unsigned hi);
        t_set_action item;
        int          phase;
        phase = (rand_count < ITEM_TARGET / 3) ? 0 :
                (rand_count < 2 * ITEM_TARGET / 3) ? 1 : 2;
        item.act   = act;
        item.lo    = lo[CPW-1:0];
        item.hi    = hi[CPW-1:0];
        item.phase = phase;
        item.drain = (phase != fill_phase);
        fill_phase = phase;
        if (in_random && act != ACT_UNUSED) rand_count++;
        actions_todo = {actions_todo, item};
    endfunction

    // Clear, build two ascending sets with a few broken appends, then compute and query
    function automatic void add_sequence(bit force_full);
        int unsigned n [2];
        int unsigned made [2];
        int unsigned next_lo [2];
        int unsigned base, gap_max, len_max, lo, hi, nops, op;
        int          s;
        case ($urandom_range(0, 3))
            0: begin
                gap_max = 6;
                len_max = 6;
                base    = $urandom_range(0, 20);
            end
            1: begin
                gap_max = 40000;
                len_max = 40000;
                base    = $urandom_range(0, 300000);
            end
            2: begin
                gap_max = 10;
                len_max = 10;
                base    = $urandom_range(2096000, 2096600);
            end
            default: begin
                gap_max = 300;
                len_max = 300;
                base    = $urandom_range(0, 1000000);
            end
        endcase
        n[0]       = force_full ? 18 : $urandom_range(0, 18);
        n[1]       = force_full ? 17 : $urandom_range(0, 18);
        made[0]    = 0;
        made[1]    = 0;
        next_lo[0] = base;
        next_lo[1] = base;
        push_action(ACT_CLEAR, $urandom_range(0, CP_MAX), $urandom_range(0, CP_MAX));
        while (made[0] < n[0] || made[1] < n[1]) begin
            s = (made[0] >= n[0]) ? 1 : (made[1] >= n[1]) ? 0 : int'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
                // broken append: touching/overlapping the tail, or inverted
                if (made[s] != 0 && $urandom_range(0, 1) == 1)
                    push_action(append_code(s), next_lo[s] - 1 - $urandom_range(0, 1),
                                next_lo[s] + $urandom_range(0, 5));
                else
                    push_action(append_code(s), next_lo[s] + 4,
                                next_lo[s] + $urandom_range(0, 3));
            end else begin
                lo         = next_lo[s] + $urandom_range(0, gap_max);
                hi         = lo + $urandom_range(0, len_max);
                next_lo[s] = hi + 2;
                made[s]++;
                push_action(append_code(s), lo, hi);
            end
        end
        nops = $urandom_range(2, 5);
        for (op = 0; op < nops; op++) begin
            case ($urandom_range(0, 3))
                0: push_action(ACT_UNION, $urandom_range(0, CP_MAX), $urandom_range(0, CP_MAX));
                1: push_action(ACT_INTER, $urandom_range(0, CP_MAX), $urandom_range(0, CP_MAX));
                2: push_action(ACT_DIFF, $urandom_range(0, CP_MAX), $urandom_range(0, CP_MAX));
                default: push_action(ACT_QUERY, base + $urandom_range(0, next_lo[0] - base + 2),
                                     $urandom_range(0, CP_MAX));
            endcase
        end
    endfunction

    function automatic void log_mismatch(string kind, t_span_result want, t_span_result got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display({"%s: want lo=%h hi=%h mem=%b st=%0d emp=%b last=%b,",
                      " got lo=%h hi=%h mem=%b st=%0d emp=%b last=%b"},
                     kind, want.lo, want.hi, want.member, want.status, want.empty, want.last,
                     got.lo, got.hi, got.member, got.status, got.empty, got.last);
    endfunction

    // Predict on each input transfer, check each result transfer, watch for a hang
    always @(posedge i_clk) begin : check_results
        t_span_result want;
        t_span_result got;
        bit           out_acc;
        if (!i_rst_n) begin
            in_acc      = 1'b0;
            idle_cycles = 0;
        end else begin
            in_acc  = i_valid && !o_stall;
            out_acc = o_valid && !i_stall;
            if (in_acc) predict_action(i_action, i_range_low, i_range_high);
            if (out_acc) begin
                got = '{lo: o_out_low, hi: o_out_high, member: o_is_member, status: o_status,
                        empty: o_empty_result, last: o_last};
                if (spans_due.size() == 0) begin
                    log_mismatch("unexpected result", '0, got);
                end else begin
                    want = spans_due.pop_front();
                    if (got !== want) log_mismatch("result mismatch", want, got);
                end
            end
            if (in_acc || out_acc) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("no transfer for %0d cycles", STALL_LIMIT);
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    // Offer the next queued item once the previous one has transferred
    always @(negedge i_clk) begin : drive_actions
        t_set_action nxt;
        bit          offer;
        offer = 1'b0;
        if (i_rst_n && (!i_valid || in_acc)) begin
            if (actions_todo.size() != 0) begin
                nxt   = actions_todo[0];
                offer = !(nxt.drain && spans_due.size() != 0)
                        && $urandom_range(0, 99) >= idle_pct(1'b1, nxt.phase);
            end
            if (offer) begin
                void'(actions_todo.pop_front());
                cur_phase    <= nxt.phase;
                i_valid      <= 1'b1;
                i_action     <= nxt.act;
                i_range_low  <= nxt.lo;
                i_range_high <= nxt.hi;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random; hold it off once for a long stretch
    always @(negedge i_clk) begin : drive_stall
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (cur_phase == 2 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < idle_pct(1'b0, cur_phase));
        end
    end

    initial begin : run_test
        int s;
        // empty sets, order and inversion rejects, extremes, touching union, unused code
        push_action(ACT_CLEAR, 0, 0);
        push_action(ACT_UNION, 0, 0);
        push_action(ACT_INTER, CP_MAX, CP_MAX);
        push_action(ACT_DIFF, 0, 0);
        push_action(ACT_QUERY, 0, 0);
        push_action(ACT_APP_A, 10, 5);
        push_action(ACT_APP_A, 0, 0);
        push_action(ACT_APP_A, 1, 3);
        push_action(ACT_APP_A, 2, 5);
        push_action(ACT_APP_A, 7, 1114111);
        push_action(ACT_APP_A, CP_MAX, CP_MAX);
        push_action(ACT_APP_B, 0, 2);
        push_action(ACT_APP_B, 4, CP_MAX - 1);
        push_action(ACT_APP_B, 6, 7);
        push_action(ACT_QUERY, CP_MAX, 0);
        push_action(ACT_QUERY, 6, CP_MAX);
        push_action(ACT_QUERY, 1114112, 0);
        push_action(ACT_UNION, 0, 0);
        push_action(ACT_INTER, 0, 0);
        push_action(ACT_DIFF, 0, 0);
        push_action(ACT_UNUSED, CP_MAX, CP_MAX);
        push_action(ACT_CLEAR, CP_MAX, CP_MAX);
        push_action(ACT_DIFF, 0, 0);

        // random part: first sequence overfills both sets
        in_random = 1'b1;
        add_sequence(1'b1);
        while (rand_count < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0)
                push_action(3'($urandom_range(0, 7)), $urandom_range(0, CP_MAX),
                            $urandom_range(0, CP_MAX));
            add_sequence(1'b0);
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain everything, then allow the block to finish any silent item
        while (actions_todo.size() != 0 || i_valid || spans_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && spans_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
